>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define RPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Types, widths and arctangent table for the relative position to spherical
// converter.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int COORD_W           = 24;
    localparam int DIFF_W            = 25;
    localparam int SQ_W              = 50;
    localparam int ANGLE_W           = 16;
    localparam int RANGE_W           = 25;
    localparam int ROOT_W            = 32;
    localparam int RAD_W             = 2 * ROOT_W;
    localparam int CORDIC_W          = 36;
    localparam int ACC_W             = 32;
    localparam int PRE_SHIFT         = 7;
    localparam int HSQ_SHIFT         = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [ACC_W-1:0]   ACC_QUARTER_POS = 32'h4000_0000;
    localparam logic [ACC_W-1:0]   ACC_QUARTER_NEG = 32'hC000_0000;
    localparam logic [ACC_W-1:0]   ACC_ROUND       = 32'h0000_8000;
    localparam logic [RANGE_W-1:0] RANGE_MAX       = {RANGE_W{1'b1}};
    localparam logic signed [ANGLE_W:0] ELEV_HI    = 17'sd16384;
    localparam logic signed [ANGLE_W:0] ELEV_LO    = -17'sd16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic signed [COORD_W-1:0] own_x;
        logic signed [COORD_W-1:0] own_y;
        logic signed [COORD_W-1:0] own_z;
    } pos_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] bearing_angle;
        logic        [RANGE_W-1:0] slant_range;
        logic signed [ANGLE_W-1:0] elevation_angle;
        logic                      range_saturated;
    } sph_t;

    function automatic logic [ACC_W-1:0] atan_entry(input int idx);
        logic [ACC_W-1:0] v;
        unique case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/relative_position_to_spherical_top.sv
// ----------------------------------------------------------------------------
// relative_position_to_spherical_top
// Converts target minus own position into bearing, slant range, elevation.
// ----------------------------------------------------------------------------
// Input channel pos/pos_valid/pos_stall carries both positions; output
// channel sph/sph_valid/sph_stall carries bearing, range, elevation and the
// saturation flag. A transfer happens when valid is high and stall is low.
// The pipeline registers differences, squares and sums in turn, then runs
// the bit-per-stage square root, the two parallel CORDIC units and one output
// register. Throughput is one transfer per cycle while sph_stall does not
// hold the pipeline.
// The whole pipeline advances on one enable; when a result sits in the
// output register and sph_stall is high, every stage holds and pos_stall is
// raised until the result is taken. Reset clears all valid bits; no result
// is pending after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module relative_position_to_spherical_top #(
    parameter int CORDIC_STAGES = rps_pkg::CORDIC_STAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pos_valid,
    output logic          pos_stall,
    input  rps_pkg::pos_t pos,
    output logic          sph_valid,
    input  logic          sph_stall,
    output rps_pkg::sph_t sph
);
    import rps_pkg::*;

    localparam int SIDE_W  = 3 * DIFF_W;
    localparam int RNG_W   = ROOT_W + 1;
    localparam int BSIDE_W = RANGE_W + 1;

    logic adv;

    logic                     d_valid_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic                     q_valid_reg;
    logic signed [DIFF_W-1:0] qdx_reg, qdy_reg, qdz_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [DIFF_W-1:0]        ax, ay, az;
    logic                     s_valid_reg;
    logic [RAD_W-1:0]         rad_h_reg, rad_s_reg;
    logic [SIDE_W-1:0]        side_reg;
    logic [SQ_W:0]            hsq;
    logic [SQ_W+1:0]          ssum;

    logic                     h_valid;
    logic [ROOT_W-1:0]        h_root;
    logic [SIDE_W-1:0]        h_side;
    logic [ROOT_W-1:0]        s_root;
    logic [ROOT_W:0]          s_rem;

    logic signed [DIFF_W-1:0]   sdx, sdy, sdz;
    logic signed [CORDIC_W-1:0] bx0, by0, bx, by, ex, ey;
    logic [ACC_W-1:0]           bbase;
    logic [RNG_W-1:0]           rng;
    logic                       sat;
    logic [BSIDE_W-1:0]         bside;

    logic                 b_valid;
    logic [ACC_W-1:0]     b_acc;
    logic [BSIDE_W-1:0]   b_side;
    logic [ACC_W-1:0]     e_acc;
    logic [ACC_W-1:0]     b_round;
    logic signed [ACC_W:0] e_sum;
    logic signed [ANGLE_W:0] e_ang;
    logic signed [ANGLE_W:0] e_clamp;

    sph_t sph_next;
    sph_t sph_reg;
    logic sph_valid_reg;

    assign adv       = !(sph_valid_reg && sph_stall);
    assign pos_stall = !adv;

    // Valid bits of the difference, square and sum stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= pos_valid;
            q_valid_reg <= d_valid_reg;
            s_valid_reg <= q_valid_reg;
        end
    end

    assign ax = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign ay = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign az = dz_reg[DIFF_W-1] ? DIFF_W'(-dz_reg) : DIFF_W'(dz_reg);

    assign hsq  = (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
    assign ssum = (SQ_W+2)'(hsq) + (SQ_W+2)'(sqz_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= DIFF_W'(pos.target_x) - DIFF_W'(pos.own_x);
            dy_reg    <= DIFF_W'(pos.target_y) - DIFF_W'(pos.own_y);
            dz_reg    <= DIFF_W'(pos.target_z) - DIFF_W'(pos.own_z);
            sqx_reg   <= SQ_W'(ax * ax);
            sqy_reg   <= SQ_W'(ay * ay);
            sqz_reg   <= SQ_W'(az * az);
            qdx_reg   <= dx_reg;
            qdy_reg   <= dy_reg;
            qdz_reg   <= dz_reg;
            rad_h_reg <= {hsq[RAD_W-HSQ_SHIFT-1:0], {HSQ_SHIFT{1'b0}}};
            rad_s_reg <= RAD_W'(ssum);
            side_reg  <= {qdx_reg, qdy_reg, qdz_reg};
        end
    end

    rps_isqrt #(
        .RW (ROOT_W),
        .SW (SIDE_W)
    ) u_sqrt_h (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (s_valid_reg),
        .rad_i   (rad_h_reg),
        .side_i  (side_reg),
        .valid_o (h_valid),
        .root_o  (h_root),
        .rem_o   (),
        .side_o  (h_side)
    );

    rps_isqrt #(
        .RW (ROOT_W),
        .SW (1)
    ) u_sqrt_s (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (s_valid_reg),
        .rad_i   (rad_s_reg),
        .side_i  (1'b0),
        .valid_o (),
        .root_o  (s_root),
        .rem_o   (s_rem),
        .side_o  ()
    );

    // Quadrant pre-rotation and range rounding
    always_comb
    begin
        {sdx, sdy, sdz} = h_side;
        bx0 = CORDIC_W'(sdx) <<< PRE_SHIFT;
        by0 = CORDIC_W'(sdy) <<< PRE_SHIFT;
        ex  = CORDIC_W'({1'b0, h_root});
        ey  = CORDIC_W'(sdz) <<< PRE_SHIFT;
        priority if (!bx0[CORDIC_W-1])
        begin
            bx    = bx0;
            by    = by0;
            bbase = '0;
        end
        else if (!by0[CORDIC_W-1])
        begin
            bx    = by0;
            by    = -bx0;
            bbase = ACC_QUARTER_POS;
        end
        else
        begin
            bx    = -by0;
            by    = bx0;
            bbase = ACC_QUARTER_NEG;
        end
        rng = RNG_W'(s_root) + ((s_rem > RNG_W'(s_root)) ? RNG_W'(1) : RNG_W'(0));
        sat = (rng > RNG_W'(RANGE_MAX));
        bside = {sat ? RANGE_MAX : rng[RANGE_W-1:0], sat};
    end

    rps_cordic #(
        .STAGES (CORDIC_STAGES),
        .W      (CORDIC_W),
        .SW     (BSIDE_W)
    ) u_cordic_bearing (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (h_valid),
        .x_i     (bx),
        .y_i     (by),
        .acc_i   (bbase),
        .side_i  (bside),
        .valid_o (b_valid),
        .acc_o   (b_acc),
        .side_o  (b_side)
    );

    rps_cordic #(
        .STAGES (CORDIC_STAGES),
        .W      (CORDIC_W),
        .SW     (1)
    ) u_cordic_elev (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (h_valid),
        .x_i     (ex),
        .y_i     (ey),
        .acc_i   ('0),
        .side_i  (1'b0),
        .valid_o (),
        .acc_o   (e_acc),
        .side_o  ()
    );

    // Round angles, clamp elevation
    always_comb
    begin
        b_round = b_acc + ACC_ROUND;
        e_sum   = $signed({e_acc[ACC_W-1], e_acc}) + $signed((ACC_W+1)'(ACC_ROUND));
        e_ang   = (ANGLE_W+1)'(e_sum >>> ANGLE_W);
        priority if (e_ang > ELEV_HI)
        begin
            e_clamp = ELEV_HI;
        end
        else if (e_ang < ELEV_LO)
        begin
            e_clamp = ELEV_LO;
        end
        else
        begin
            e_clamp = e_ang;
        end
        sph_next.bearing_angle   = b_round[ACC_W-1:ACC_W-ANGLE_W];
        sph_next.slant_range     = b_side[BSIDE_W-1:1];
        sph_next.elevation_angle = e_clamp[ANGLE_W-1:0];
        sph_next.range_saturated = b_side[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sph_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sph_reg <= sph_next;
        end
    end

    assign sph_valid = sph_valid_reg;
    assign sph       = sph_reg;

    `RPS_ASSERT_NOW(a_stall_source, clk, rst_n, pos_stall, sph_valid && sph_stall)
    `RPS_ASSERT_NOW(a_sat_range, clk, rst_n, sph_valid && sph.range_saturated,
        sph.slant_range == RANGE_MAX)
    `RPS_ASSERT_NOW(a_elev_limit, clk, rst_n, sph_valid,
        sph.elevation_angle <= 16'sd16384 && sph.elevation_angle >= -16'sd16384)
    `RPS_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, pos_stall, $stable(d_valid_reg))

endmodule

>>> rtl/rps_isqrt.sv
// ----------------------------------------------------------------------------
// rps_isqrt
// Pipelined integer square root, one result bit per stage, with remainder.
// ----------------------------------------------------------------------------
module rps_isqrt #(
    parameter int RW = rps_pkg::ROOT_W,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_i,
    input  logic [2*RW-1:0] rad_i,
    input  logic [SW-1:0]   side_i,
    output logic            valid_o,
    output logic [RW-1:0]   root_o,
    output logic [RW:0]     rem_o,
    output logic [SW-1:0]   side_o
);
    import rps_pkg::*;

    logic            valid_reg [RW];
    logic [RW:0]     rem_reg   [RW];
    logic [RW-1:0]   root_reg  [RW];
    logic [2*RW-1:0] rad_reg   [RW];
    logic [SW-1:0]   side_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            valid_cur;
        logic [RW:0]     rem_cur;
        logic [RW-1:0]   root_cur;
        logic [2*RW-1:0] rad_cur;
        logic [SW-1:0]   side_cur;
        logic [RW+2:0]   rem_sh;
        logic [RW+2:0]   trial;
        logic            ge;
        logic [RW+2:0]   rem_sub;
        logic [RW:0]     rem_next;
        logic [RW-1:0]   root_next;

        if (k == 0) begin : g_first
            assign valid_cur = valid_i;
            assign rem_cur   = '0;
            assign root_cur  = '0;
            assign rad_cur   = rad_i;
            assign side_cur  = side_i;
        end else begin : g_rest
            assign valid_cur = valid_reg[k-1];
            assign rem_cur   = rem_reg[k-1];
            assign root_cur  = root_reg[k-1];
            assign rad_cur   = rad_reg[k-1];
            assign side_cur  = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh    = {rem_cur, rad_cur[2*RW-1:2*RW-2]};
            trial     = {1'b0, root_cur, 2'b01};
            ge        = (rem_sh >= trial);
            rem_sub   = ge ? (rem_sh - trial) : rem_sh;
            rem_next  = rem_sub[RW:0];
            root_next = {root_cur[RW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_cur[2*RW-3:0], 2'b00};
                side_reg[k] <= side_cur;
            end
        end
    end

    assign valid_o = valid_reg[RW-1];
    assign root_o  = root_reg[RW-1];
    assign rem_o   = rem_reg[RW-1];
    assign side_o  = side_reg[RW-1];

endmodule

>>> rtl/rps_cordic.sv
// ----------------------------------------------------------------------------
// rps_cordic
// Pipelined vectoring CORDIC, one micro-rotation per stage, binary angle out.
// ----------------------------------------------------------------------------
module rps_cordic #(
    parameter int STAGES = rps_pkg::CORDIC_STAGES_DEF,
    parameter int W      = rps_pkg::CORDIC_W,
    parameter int SW     = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_i,
    input  logic signed [W-1:0]        x_i,
    input  logic signed [W-1:0]        y_i,
    input  logic [rps_pkg::ACC_W-1:0]  acc_i,
    input  logic [SW-1:0]              side_i,
    output logic                       valid_o,
    output logic [rps_pkg::ACC_W-1:0]  acc_o,
    output logic [SW-1:0]              side_o
);
    import rps_pkg::*;

    logic                valid_reg [STAGES];
    logic signed [W-1:0] x_reg     [STAGES];
    logic signed [W-1:0] y_reg     [STAGES];
    logic [ACC_W-1:0]    acc_reg   [STAGES];
    logic [SW-1:0]       side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [ACC_W-1:0] ATAN_K = atan_entry(k);

        logic                valid_cur;
        logic signed [W-1:0] x_cur;
        logic signed [W-1:0] y_cur;
        logic [ACC_W-1:0]    acc_cur;
        logic [SW-1:0]       side_cur;
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        logic signed [W-1:0] x_next;
        logic signed [W-1:0] y_next;
        logic [ACC_W-1:0]    acc_next;

        if (k == 0) begin : g_first
            assign valid_cur = valid_i;
            assign x_cur     = x_i;
            assign y_cur     = y_i;
            assign acc_cur   = acc_i;
            assign side_cur  = side_i;
        end else begin : g_rest
            assign valid_cur = valid_reg[k-1];
            assign x_cur     = x_reg[k-1];
            assign y_cur     = y_reg[k-1];
            assign acc_cur   = acc_reg[k-1];
            assign side_cur  = side_reg[k-1];
        end

        always_comb
        begin
            xs = x_cur >>> k;
            ys = y_cur >>> k;
            priority if (y_cur > 0)
            begin
                x_next   = x_cur + ys;
                y_next   = y_cur - xs;
                acc_next = acc_cur + ATAN_K;
            end
            else if (y_cur < 0)
            begin
                x_next   = x_cur - ys;
                y_next   = y_cur + xs;
                acc_next = acc_cur - ATAN_K;
            end
            else
            begin
                x_next   = x_cur;
                y_next   = y_cur;
                acc_next = acc_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                acc_reg[k]  <= acc_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign valid_o = valid_reg[STAGES-1];
    assign acc_o   = acc_reg[STAGES-1];
    assign side_o  = side_reg[STAGES-1];

endmodule
